[rtl/core/deadline_sorted_timer_queue_assert.svh]
// Assertion macros shared by the timer queue RTL modules.
// Depends on signals named clock and reset in the module that uses them.
`ifndef DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DSTQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer queue assertion failed");

// Next-cycle implication, checked outside reset.
`define DSTQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer queue assertion failed");

`endif

[rtl/core/dstq_pkg.sv]
// Package for the deadline-sorted timer queue: sizes, codes and the
// transaction and control struct types. No dependencies.
`default_nettype none

package dstq_pkg;

   localparam int DEPTH       = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int SEC_W       = 40;
   localparam int TAG_W       = 16;
   localparam int DELAY_W     = 32;

   typedef enum logic [0:0] {
      FUNC_ADD  = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      KIND_ADDED   = 2'd0,
      KIND_FULL    = 2'd1,
      KIND_EXPIRED = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RD_CUR   = 2'd0,
      RD_PREV  = 2'd1,
      RD_PREV2 = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic                       func;
      logic signed [DELAY_W-1:0]  delay_seconds;
      logic [TAG_W-1:0]           tag;
   } req_type;

   typedef struct packed {
      kind_type                   kind;
      logic [TAG_W-1:0]           out_tag;
      logic [SEC_W-1:0]           out_deadline;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic [SEC_W-1:0] deadline;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic       acc_add;
      logic       acc_tick;
      rd_sel_type rd_sel;
      logic       wr_shift;
      logic       wr_new;
      logic       pend_load;
      logic       emit;
      kind_type   emit_kind;
      logic       emit_last;
      logic       commit;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic idx_zero;
      logic idx_one;
      logic scan_more;
      logic rd_gt_dl;
      logic rd_le_now;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/core/deadline_sorted_timer_queue.sv]
// Top level of the deadline-sorted timer queue: joins the controller and
// the datapath. Depends on dstq_pkg, dstq_ctrl and dstq_datapath.
// Usage: the request channel (req_valid, req_ready, req_payload) carries
// one transaction per command. An add (func 0) places a reminder with
// deadline now plus delay_seconds, clamped at zero and at the counter top,
// behind all entries with an equal or earlier deadline; it answers with one
// added or queue-full transaction. A tick (func 1) advances the second
// counter and answers with every due entry, earliest first, at most sixteen,
// or with a single nothing-expired transaction; the last flag marks the
// final response of each request.
// Flow: a request is taken only while the controller is idle. An add moves
// each later entry up one slot per cycle from the tail, and the walk stops at
// the first entry with an equal or earlier deadline; a rejected add moves
// nothing. A tick reads each due entry through the registered read port of
// the entry memory, and its scan stops at an entry not yet due.
// Responses sit in an output register; while rsp_ready is low the block holds
// that transaction and stalls at its next response, and takes new requests
// once idle. Reset clears the second counter and empties the queue.
`default_nettype none

module deadline_sorted_timer_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dstq_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dstq_pkg::rsp_type      rsp_payload
);

   // Command and status groups between the sequencer and the datapath.
   dstq_pkg::dp_cmd_type    cmd;
   dstq_pkg::dp_status_type status;

   dstq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_payload.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dstq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[rtl/core/dstq_datapath.sv]
// Datapath of the timer queue: entry ring memory, second counter, walk
// index, pending expiry and the result register. Depends on dstq_pkg.
`default_nettype none
`include "deadline_sorted_timer_queue_assert.svh"

module dstq_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dstq_pkg::req_type       req_payload,
   input  wire dstq_pkg::dp_cmd_type    cmd,
   output dstq_pkg::dp_status_type      status,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output dstq_pkg::rsp_type            rsp_payload
);

   // Physical slot of logical position offset, counted from the ring head.
   function automatic logic [dstq_pkg::IDX_W-1:0] ring_index(
      input logic [dstq_pkg::IDX_W-1:0] base,
      input logic [dstq_pkg::CNT_W-1:0] offset
   );
      logic [dstq_pkg::CNT_W:0] sum;
      sum = (dstq_pkg::CNT_W + 1)'(base) + (dstq_pkg::CNT_W + 1)'(offset);
      if (sum >= (dstq_pkg::CNT_W + 1)'(dstq_pkg::DEPTH)) begin
         sum = sum - (dstq_pkg::CNT_W + 1)'(dstq_pkg::DEPTH);
      end
      return sum[dstq_pkg::IDX_W-1:0];
   endfunction

   dstq_pkg::entry_type             mem_ff [dstq_pkg::DEPTH];
   dstq_pkg::entry_type             rd_data_ff;
   dstq_pkg::entry_type             pend_ff;
   dstq_pkg::rsp_type               rsp_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dstq_pkg::SEC_W-1:0]      now_ff, now_in;
   logic [dstq_pkg::SEC_W-1:0]      dl_ff;
   logic [dstq_pkg::TAG_W-1:0]      tag_ff;
   logic [dstq_pkg::IDX_W-1:0]      head_ff, head_in;
   logic [dstq_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [dstq_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic [dstq_pkg::CNT_W-1:0]      rd_off;
   logic [dstq_pkg::IDX_W-1:0]      rd_addr;
   logic [dstq_pkg::IDX_W-1:0]      wr_addr;
   logic signed [dstq_pkg::SEC_W+1:0] sum_wide;
   logic [dstq_pkg::SEC_W-1:0]      dl_calc;

   // Deadline of an add: now plus signed delay, clamped to the counter range.
   assign sum_wide = $signed({2'b00, now_ff})
                   + (dstq_pkg::SEC_W + 2)'(req_payload.delay_seconds);

   always_comb begin
      priority if (sum_wide[dstq_pkg::SEC_W+1]) begin
         dl_calc = '0;
      end else if (sum_wide[dstq_pkg::SEC_W]) begin
         dl_calc = '1;
      end else begin
         dl_calc = sum_wide[dstq_pkg::SEC_W-1:0];
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         dstq_pkg::RD_PREV: begin
            rd_off = (idx_ff != '0) ? idx_ff - 1'b1 : '0;
         end
         dstq_pkg::RD_PREV2: begin
            rd_off = (idx_ff >= dstq_pkg::CNT_W'(2)) ? idx_ff - dstq_pkg::CNT_W'(2) : '0;
         end
         default: begin
            rd_off = idx_ff;
         end
      endcase
   end

   assign rd_addr = ring_index(head_ff, rd_off);
   assign wr_addr = ring_index(head_ff, idx_ff);

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (cmd.wr_shift) begin
         mem_ff[wr_addr] <= rd_data_ff;
      end else if (cmd.wr_new) begin
         mem_ff[wr_addr] <= '{deadline: dl_ff, tag: tag_ff};
      end
   end

   always_comb begin
      now_in   = now_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      head_in  = head_ff;
      if (cmd.acc_tick && now_ff != '1) begin
         now_in = now_ff + 1'b1;
      end
      priority if (cmd.acc_add) begin
         idx_in = count_ff;
      end else if (cmd.acc_tick) begin
         idx_in = '0;
      end else if (cmd.wr_shift) begin
         idx_in = idx_ff - 1'b1;
      end else if (cmd.pend_load) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.wr_new) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.commit) begin
         count_in = count_ff - idx_ff;
         head_in  = wr_addr;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         idx_ff       <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_add) begin
         dl_ff  <= dl_calc;
         tag_ff <= req_payload.tag;
      end
      if (cmd.pend_load) begin
         pend_ff <= rd_data_ff;
      end
      if (cmd.emit) begin
         rsp_ff.kind <= cmd.emit_kind;
         rsp_ff.last <= cmd.emit_last;
         unique case (cmd.emit_kind)
            dstq_pkg::KIND_ADDED: begin
               rsp_ff.out_tag      <= tag_ff;
               rsp_ff.out_deadline <= dl_ff;
            end
            dstq_pkg::KIND_FULL: begin
               rsp_ff.out_tag      <= '0;
               rsp_ff.out_deadline <= dl_ff;
            end
            dstq_pkg::KIND_EXPIRED: begin
               rsp_ff.out_tag      <= pend_ff.tag;
               rsp_ff.out_deadline <= pend_ff.deadline;
            end
            default: begin
               rsp_ff.out_tag      <= '0;
               rsp_ff.out_deadline <= '0;
            end
         endcase
      end
   end

   assign status.full      = (count_ff == dstq_pkg::CNT_W'(dstq_pkg::DEPTH));
   assign status.idx_zero  = (idx_ff == '0);
   assign status.idx_one   = (idx_ff == dstq_pkg::CNT_W'(1));
   assign status.scan_more = (idx_ff < count_ff) && (32'(idx_ff) < dstq_pkg::MAX_RESULTS);
   assign status.rd_gt_dl  = (rd_data_ff.deadline > dl_ff);
   assign status.rd_le_now = (rd_data_ff.deadline <= now_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `DSTQ_ASSERT_IMPL(a_emit_has_room, cmd.emit, !rsp_valid_ff || rsp_ready)
   `DSTQ_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= dstq_pkg::CNT_W'(dstq_pkg::DEPTH))
   `DSTQ_ASSERT_NEXT(a_insert_grows, cmd.wr_new, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

[rtl/core/dstq_ctrl.sv]
// Controller state machine of the timer queue: sequences insertion walks
// and expiry scans over the datapath. Depends on dstq_pkg.
`default_nettype none
`include "deadline_sorted_timer_queue_assert.svh"

module dstq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_func,
   output logic                         req_ready,
   input  wire dstq_pkg::dp_status_type status,
   output dstq_pkg::dp_cmd_type         cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_ADD_CHK  = 7'b0000010,
      ST_ADD_CMP  = 7'b0000100,
      ST_ADD_PUT  = 7'b0001000,
      ST_TICK_RD  = 7'b0010000,
      ST_TICK_CHK = 7'b0100000,
      ST_TICK_FIN = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = dstq_pkg::RD_CUR;
      cmd.emit_kind = dstq_pkg::KIND_NONE;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == dstq_pkg::FUNC_ADD) begin
                  cmd.acc_add = 1'b1;
                  state_in    = ST_ADD_CHK;
               end else begin
                  cmd.acc_tick = 1'b1;
                  state_in     = ST_TICK_RD;
               end
            end
         end
         ST_ADD_CHK: begin
            cmd.rd_sel = dstq_pkg::RD_PREV;
            priority if (status.full) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = dstq_pkg::KIND_FULL;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.idx_zero) begin
               state_in = ST_ADD_PUT;
            end else begin
               state_in = ST_ADD_CMP;
            end
         end
         ST_ADD_CMP: begin
            // Read one slot ahead so that the shift steps follow back to back.
            cmd.rd_sel = dstq_pkg::RD_PREV2;
            if (status.rd_gt_dl) begin
               cmd.wr_shift = 1'b1;
               if (status.idx_one) begin
                  state_in = ST_ADD_PUT;
               end
            end else begin
               state_in = ST_ADD_PUT;
            end
         end
         ST_ADD_PUT: begin
            if (status.out_free) begin
               cmd.wr_new    = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = dstq_pkg::KIND_ADDED;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            if (status.scan_more) begin
               state_in = ST_TICK_CHK;
            end else begin
               state_in = ST_TICK_FIN;
            end
         end
         ST_TICK_CHK: begin
            // The previous due entry goes out only once this one is known
            // to be due as well, so that it is not the last one.
            if (status.rd_le_now) begin
               if (status.idx_zero) begin
                  cmd.pend_load = 1'b1;
                  state_in      = ST_TICK_RD;
               end else if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = dstq_pkg::KIND_EXPIRED;
                  cmd.pend_load = 1'b1;
                  state_in      = ST_TICK_RD;
               end
            end else begin
               state_in = ST_TICK_FIN;
            end
         end
         ST_TICK_FIN: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               cmd.emit_kind = status.idx_zero ? dstq_pkg::KIND_NONE
                                               : dstq_pkg::KIND_EXPIRED;
               cmd.commit    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DSTQ_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != ST_IDLE)
   `DSTQ_ASSERT_IMPL(a_no_insert_when_full, cmd.wr_new, !status.full)

endmodule

`default_nettype wire

[tb/deadline_sorted_timer_queue_tb.sv]
// Self-checking testbench for the deadline-sorted timer queue. It holds a
// scoreboard class that predicts every response and plain tasks that drive
// the request channel. Depends on dstq_pkg and deadline_sorted_timer_queue.
`timescale 1ns / 1ps

module deadline_sorted_timer_queue_tb;

   localparam int ITEM_TARGET = 310;   // least number of request transactions to send
   localparam int QUIET_LIMIT = 2000;  // cycles without any transaction
   localparam int END_TAIL    = 64;    // settle time after the last response

   // Scoreboard: keeps its own copy of the timer queue, turns each accepted
   // request into the responses it must cause, and compares each accepted
   // response with the oldest one still due.
   class timer_queue_scoreboard;
      logic [dstq_pkg::SEC_W-1:0] now_sec;
      dstq_pkg::entry_type        slots[dstq_pkg::DEPTH];
      int unsigned                fill;
      dstq_pkg::rsp_type          due_responses[$];
      int unsigned                error_count;

      function new();
         now_sec     = '0;
         fill        = 0;
         error_count = 0;
      endfunction

      function void note_request(dstq_pkg::req_type req);
         longint                     sum;
         logic [dstq_pkg::SEC_W-1:0] deadline;
         int unsigned                pos;
         int unsigned                n;

         if (req.func == dstq_pkg::FUNC_ADD) begin
            // The delay is signed; the sum is clamped at zero and at the
            // counter top.
            sum = longint'({24'd0, now_sec}) + longint'($signed(req.delay_seconds));
            if (sum < 0) begin
               deadline = '0;
            end else if (sum > longint'({24'd0, {dstq_pkg::SEC_W{1'b1}}})) begin
               deadline = '1;
            end else begin
               deadline = sum[dstq_pkg::SEC_W-1:0];
            end
            if (fill >= dstq_pkg::DEPTH) begin
               due_responses.push_back('{kind: dstq_pkg::KIND_FULL, out_tag: 16'd0,
                                         out_deadline: deadline, last: 1'b1});
            end else begin
               // Equal deadlines keep arrival order: skip past them.
               pos = 0;
               while (pos < fill && slots[pos].deadline <= deadline) pos++;
               for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
               slots[pos] = '{deadline: deadline, tag: req.tag};
               fill++;
               due_responses.push_back('{kind: dstq_pkg::KIND_ADDED, out_tag: req.tag,
                                         out_deadline: deadline, last: 1'b1});
            end
         end else begin
            if (now_sec != {dstq_pkg::SEC_W{1'b1}}) now_sec++;
            n = 0;
            while (n < fill && n < dstq_pkg::MAX_RESULTS && slots[n].deadline <= now_sec)
               n++;
            if (n == 0) begin
               due_responses.push_back('{kind: dstq_pkg::KIND_NONE, out_tag: 16'd0,
                                         out_deadline: '0, last: 1'b1});
            end else begin
               for (int i = 0; i < n; i++) begin
                  due_responses.push_back('{kind: dstq_pkg::KIND_EXPIRED,
                                            out_tag: slots[i].tag,
                                            out_deadline: slots[i].deadline,
                                            last: (i + 1 == n)});
               end
               for (int i = n; i < fill; i++) slots[i-n] = slots[i];
               fill -= n;
            end
         end
      endfunction

      function void report_field(string field, logic [63:0] want, logic [63:0] got);
         $display("%0t: response %s mismatch, expected %0h, actual %0h",
                  $time, field, want, got);
         error_count++;
      endfunction

      function void check_response(dstq_pkg::rsp_type got);
         dstq_pkg::rsp_type want;

         if (due_responses.size() == 0) begin
            $display("%0t: response with none due, actual kind %0d tag %0h deadline %0h",
                     $time, got.kind, got.out_tag, got.out_deadline);
            error_count++;
            return;
         end
         want = due_responses.pop_front();
         if (got.kind !== want.kind) report_field("kind", want.kind, got.kind);
         if (got.out_tag !== want.out_tag) report_field("tag", want.out_tag, got.out_tag);
         if (got.out_deadline !== want.out_deadline)
            report_field("deadline", want.out_deadline, got.out_deadline);
         if (got.last !== want.last) report_field("last", want.last, got.last);
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   dstq_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   dstq_pkg::rsp_type rsp_payload;

   timer_queue_scoreboard sb = new();

   // When calm is set, neither side inserts idle cycles, so the block also
   // sees stretches of back-to-back traffic.
   bit          calm = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned items_sent = 0;

   deadline_sorted_timer_queue i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Reset is held at the start and never raised again.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Monitor. Both channels are sampled at the rising edge. A response taken
   // at this edge can never belong to a request taken at the same edge, so the
   // response is checked before the request is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_payload);
         if (req_valid && req_ready) sb.note_request(req_payload);
      end
   end

   // Response side pacing. After each accepted response transaction the
   // receiver draws a random stall, possibly none, before it is ready again.
   always @(posedge clock) begin : rsp_pacing
      int unsigned draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (!rsp_ready) begin
         if (rsp_hold == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_hold <= rsp_hold - 1;
         end
      end else if (rsp_valid) begin
         draw = calm ? 0 : $urandom_range(0, 10);
         if (draw != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= draw - 1;
         end
      end
   end

   // Sends one request transaction. A random gap comes first; valid is only
   // dropped for a real gap, so back-to-back transactions keep it high. The
   // task returns at the edge where the transaction is accepted.
   task automatic send_request(input logic func_bit,
                               input logic [dstq_pkg::DELAY_W-1:0] delay,
                               input logic [dstq_pkg::TAG_W-1:0] tag);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{func: func_bit, delay_seconds: delay, tag: tag};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Holds the request channel idle until every predicted response has come.
   // A first clock edge lets the monitor note the transaction just accepted.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_responses.size() != 0) @(posedge clock);
   endtask

   // Any stretch without a single transaction on either channel that runs
   // past the limit means the block has hung.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int unsigned                  burst;
      int unsigned                  pick;
      logic [dstq_pkg::DELAY_W-1:0] delay;
      bit                           drained_mid;

      drained_mid = 1'b0;
      @(negedge reset);
      @(posedge clock);

      // Directed part. At second zero: the most negative delay clamps to a
      // deadline of zero, a zero delay lands on the same deadline behind it,
      // and two equal deadlines check that arrival order is kept.
      send_request(dstq_pkg::FUNC_ADD, 32'h8000_0000, 16'h0000);
      send_request(dstq_pkg::FUNC_ADD, 32'd0, 16'hFFFF);
      send_request(dstq_pkg::FUNC_ADD, 32'd1, 16'($urandom));
      send_request(dstq_pkg::FUNC_ADD, 32'd3, 16'($urandom));
      send_request(dstq_pkg::FUNC_ADD, 32'd3, 16'($urandom));
      // Ticks carry random add fields, which the block must ignore. The
      // first expires three entries, the second nothing.
      send_request(dstq_pkg::FUNC_TICK, $urandom, 16'($urandom));
      send_request(dstq_pkg::FUNC_TICK, $urandom, 16'($urandom));
      // Fill the queue, then try two adds at the delay extremes while it is
      // full. The next tick expires all sixteen entries at once.
      repeat (14) send_request(dstq_pkg::FUNC_ADD, 32'd1, 16'($urandom));
      send_request(dstq_pkg::FUNC_ADD, 32'h7FFF_FFFF, 16'hFFFF);
      send_request(dstq_pkg::FUNC_ADD, 32'h8000_0000, 16'($urandom));
      send_request(dstq_pkg::FUNC_TICK, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(dstq_pkg::FUNC_TICK, 32'h0000_0000, 16'h0000);
      wait_for_drain();

      // Random part: bursts of adds alternate with bursts of ticks. Most
      // delays are short so entries actually come due; a few are negative
      // or span the whole field, and those in the far future stay queued.
      while (items_sent < ITEM_TARGET) begin
         if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
            wait_for_drain();
            drained_mid = 1'b1;
         end
         calm  = ($urandom_range(0, 4) == 0);
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               delay = $urandom;
            end else if (pick < 8) begin
               delay = {1'b1, 31'($urandom)};
            end else begin
               delay = $urandom_range(0, 24) - 4;
            end
            send_request(dstq_pkg::FUNC_ADD, delay, 16'($urandom));
         end
         burst = $urandom_range(1, 10);
         repeat (burst) send_request(dstq_pkg::FUNC_TICK, $urandom, 16'($urandom));
      end

      // Let every response arrive, then watch a little longer for strays.
      wait_for_drain();
      calm = 1'b0;
      repeat (END_TAIL) @(posedge clock);
      if (sb.error_count == 0 && sb.due_responses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
